@@ src/mnr_pkg.sv @@
// Shared types and constants for the magnetization renormalize pipeline.
// Every other file in src uses this package through scoped names.
package mnr_pkg;

  localparam int DW   = 24;          // component and ms width
  localparam int SW   = 2 * DW;      // sum of three squares
  localparam int QW   = DW + 16;     // isqrt(sum * 2^32), also rescale numerator
  localparam int RMW  = QW + 2;      // square-root remainder
  localparam int RB   = 18;          // ratio width, Q2.16
  localparam int FB   = 16;          // fraction bits of the ratio
  localparam int QB   = DW + 1;      // rescale quotient bits
  localparam int RW   = RB;          // rescale remainder

  localparam logic [1:0] MODE_CLAMP = 2'd0;
  localparam logic [1:0] MODE_RENORM = 2'd1;

  localparam logic [1:0] ST_KEEP  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_DRIFT = 2'd2;

  localparam logic       REG_MODE = 1'b0;
  localparam logic       REG_TOL  = 1'b1;

  localparam logic [RB-1:0] Q_ONE = RB'(1) << FB;

  typedef struct packed {
    logic signed [DW-1:0] mx;
    logic signed [DW-1:0] my;
    logic signed [DW-1:0] mz;
    logic signed [DW-1:0] ms;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] mx_out;
    logic signed [DW-1:0] my_out;
    logic signed [DW-1:0] mz_out;
    logic [RB-1:0]        ratio;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    in_item_t        vec;
    logic [SW-1:0]   s;
    logic [RMW-1:0]  rem;
    logic [QW-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    in_item_t        vec;
    logic [RB-1:0]   ql;
    logic [DW-1:0]   rem;
    logic [RB-1:0]   r;
    logic            sat;
    logic            pos;
  } rdiv_t;

  typedef struct packed {
    logic [QB-1:0]   nl;
    logic [RW-1:0]   rem;
    logic [QB-1:0]   q;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    in_item_t        vec;
    logic [RB-1:0]   r;
    logic [1:0]      status;
    logic            scale;
    lane_t [2:0]     lanes;
  } rsc_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] c);
    mag = c[DW-1] ? DW'(-c) : DW'(c);
  endfunction

endpackage

@@ src/mnr_sqrt_cell.sv @@
// One cell of the square-root chain: settles one root bit per transfer.
// Depends on mnr_pkg.
module mnr_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          v_i,
  input  mnr_pkg::sqrt_t d_i,
  output logic          rdy_o,
  output logic          v_o,
  output mnr_pkg::sqrt_t d_o,
  input  logic          rdy_i
);
  logic [mnr_pkg::RMW-1:0] t_rem, trial;
  logic                    take;
  mnr_pkg::sqrt_t          nxt;

  always_comb begin
    t_rem = {d_i.rem[mnr_pkg::RMW-3:0], d_i.s[mnr_pkg::SW-1 -: 2]};
    trial = {d_i.root, 2'b01};
    take  = t_rem >= trial;
    nxt      = d_i;
    nxt.s    = {d_i.s[mnr_pkg::SW-3:0], 2'b00};
    nxt.rem  = take ? t_rem - trial : t_rem;
    nxt.root = {d_i.root[mnr_pkg::QW-2:0], take};
  end

  assign rdy_o = !v_o || rdy_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (rdy_o) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_o <= nxt;
    end
  end
endmodule

@@ src/mnr_div_cell.sv @@
// One cell of the ratio divider chain: one quotient bit of root / ms.
// Depends on mnr_pkg.
module mnr_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          v_i,
  input  mnr_pkg::rdiv_t d_i,
  output logic          rdy_o,
  output logic          v_o,
  output mnr_pkg::rdiv_t d_o,
  input  logic          rdy_i
);
  logic [mnr_pkg::DW:0] t, msu;
  logic                 take;
  mnr_pkg::rdiv_t       nxt;

  always_comb begin
    t    = {d_i.rem, d_i.ql[mnr_pkg::RB-1]};
    msu  = {1'b0, d_i.vec.ms};
    take = t >= msu;
    nxt     = d_i;
    nxt.ql  = {d_i.ql[mnr_pkg::RB-2:0], 1'b0};
    nxt.rem = take ? mnr_pkg::DW'(t - msu) : mnr_pkg::DW'(t);
    nxt.r   = {d_i.r[mnr_pkg::RB-2:0], take};
  end

  assign rdy_o = !v_o || rdy_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (rdy_o) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_o <= nxt;
    end
  end
endmodule

@@ src/mnr_rsc_cell.sv @@
// One cell of the rescale chain: one quotient bit for each of the three
// components divided by the ratio. Depends on mnr_pkg.
module mnr_rsc_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         v_i,
  input  mnr_pkg::rsc_t d_i,
  output logic         rdy_o,
  output logic         v_o,
  output mnr_pkg::rsc_t d_o,
  input  logic         rdy_i
);
  logic [mnr_pkg::RW:0] t [3];
  logic [mnr_pkg::RW:0] ru;
  logic [2:0]           take;
  mnr_pkg::rsc_t        nxt;

  always_comb begin
    ru  = {1'b0, d_i.r};
    nxt = d_i;
    for (int k = 0; k < 3; k++) begin
      t[k]    = {d_i.lanes[k].rem, d_i.lanes[k].nl[mnr_pkg::QB-1]};
      take[k] = t[k] >= ru;
      nxt.lanes[k].nl  = {d_i.lanes[k].nl[mnr_pkg::QB-2:0], 1'b0};
      nxt.lanes[k].rem = take[k] ? mnr_pkg::RW'(t[k] - ru) : mnr_pkg::RW'(t[k]);
      nxt.lanes[k].q   = {d_i.lanes[k].q[mnr_pkg::QB-2:0], take[k]};
    end
  end

  assign rdy_o = !v_o || rdy_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (rdy_o) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_i) begin
      d_o <= nxt;
    end
  end
endmodule

@@ src/magnetization_renormalize_top.sv @@
// Top level of the magnetization renormalize pipeline.
// Depends on mnr_pkg, mnr_sqrt_cell, mnr_div_cell and mnr_rsc_cell.
//
// One vector transfer is taken per clock and one result leaves per clock
// while nothing stalls. The pipeline is made of three bit-per-cell chains:
// 40 square-root cells, 18 ratio divider cells and 25 rescale divider
// cells, plus six plain stages. Every stage holds its item until the next
// one frees, so stalls on the result side fill the chain before the input
// side is stalled. The user must write mode and tolerance through the cfg
// port only while the pipe is empty; the block itself does not enforce it.
module magnetization_renormalize_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mnr_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output mnr_pkg::out_item_t  result,
  input  logic                cfg_wr,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_data
);
  localparam int NSQ = mnr_pkg::QW;
  localparam int NDV = mnr_pkg::RB;
  localparam int NRS = mnr_pkg::QB;

  typedef struct packed {
    mnr_pkg::in_item_t          vec;
    logic [2:0][mnr_pkg::SW-2:0] sq;
  } prod_t;

  typedef struct packed {
    mnr_pkg::in_item_t          vec;
    logic [mnr_pkg::RB-1:0]     r;
    logic [1:0]                 status;
    logic                       scale;
    logic [2:0][mnr_pkg::QW-1:0] num;
  } dec_t;

  logic [1:0]  mode;
  logic [15:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= mnr_pkg::MODE_RENORM;
      tolerance <= 16'd6554;
    end else if (cfg_wr) begin
      case (cfg_addr)
        mnr_pkg::REG_MODE: mode      <= cfg_data[1:0];
        mnr_pkg::REG_TOL:  tolerance <= cfg_data;
        default:           mode      <= mode;
      endcase
    end
  end

  // Products stage.
  logic  p_v, p_rdy;
  prod_t p_d;
  logic  s_rdy;

  assign p_rdy      = !p_v || s_rdy;
  assign item_stall = !p_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (p_rdy) begin
      p_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && item_valid) begin
      p_d.vec   <= item;
      p_d.sq[0] <= (mnr_pkg::SW-1)'(mnr_pkg::mag(item.mx) * mnr_pkg::mag(item.mx));
      p_d.sq[1] <= (mnr_pkg::SW-1)'(mnr_pkg::mag(item.my) * mnr_pkg::mag(item.my));
      p_d.sq[2] <= (mnr_pkg::SW-1)'(mnr_pkg::mag(item.mz) * mnr_pkg::mag(item.mz));
    end
  end

  // Sum stage feeds the square-root chain.
  logic           sq_v   [NSQ+1];
  mnr_pkg::sqrt_t sq_d   [NSQ+1];
  logic           sq_rdy [NSQ+1];

  assign s_rdy = sq_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (sq_rdy[0]) begin
      sq_v[0] <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[0] && p_v) begin
      sq_d[0].vec  <= p_d.vec;
      sq_d[0].s    <= mnr_pkg::SW'(p_d.sq[0]) + mnr_pkg::SW'(p_d.sq[1])
                      + mnr_pkg::SW'(p_d.sq[2]);
      sq_d[0].rem  <= '0;
      sq_d[0].root <= '0;
    end
  end

  logic d0_rdy;
  assign sq_rdy[0]  = !sq_v[0] || sq_rdy[1];
  assign sq_rdy[NSQ] = !sq_v[NSQ] || d0_rdy;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    mnr_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .v_i(sq_v[i]), .d_i(sq_d[i]), .rdy_o(),
      .v_o(sq_v[i+1]), .d_o(sq_d[i+1]), .rdy_i(sq_rdy[i+2 > NSQ ? NSQ : i+2])
    );
  end

  // Ready of stage i, the output register of cell i-1, is computed here from its state.
  for (genvar i = 1; i < NSQ; i++) begin : g_sq_rdy
    assign sq_rdy[i] = !sq_v[i] || sq_rdy[i+1];
  end

  // Ratio divider setup: saturation check and first remainder.
  logic           dv_v   [NDV+1];
  mnr_pkg::rdiv_t dv_d   [NDV+1];
  logic           dv_rdy [NDV+1];
  logic [mnr_pkg::QW:0] ms_hi;

  assign d0_rdy = !dv_v[0] || dv_rdy[1];
  assign ms_hi  = (mnr_pkg::QW+1)'(mnr_pkg::mag(sq_d[NSQ].vec.ms)) << mnr_pkg::RB;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (d0_rdy) begin
      dv_v[0] <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (d0_rdy && sq_v[NSQ]) begin
      dv_d[0].vec <= sq_d[NSQ].vec;
      dv_d[0].ql  <= sq_d[NSQ].root[mnr_pkg::RB-1:0];
      dv_d[0].rem <= mnr_pkg::DW'(sq_d[NSQ].root[mnr_pkg::QW-1:mnr_pkg::RB]);
      dv_d[0].r   <= '0;
      dv_d[0].sat <= {1'b0, sq_d[NSQ].root} >= ms_hi;
      dv_d[0].pos <= !sq_d[NSQ].vec.ms[mnr_pkg::DW-1] && (sq_d[NSQ].vec.ms != '0);
    end
  end

  assign dv_rdy[0] = d0_rdy;
  logic e1_rdy;
  assign dv_rdy[NDV] = !dv_v[NDV] || e1_rdy;

  for (genvar i = 0; i < NDV; i++) begin : g_dv
    mnr_div_cell u_cell (
      .clk(clk), .rst(rst),
      .v_i(dv_v[i]), .d_i(dv_d[i]), .rdy_o(),
      .v_o(dv_v[i+1]), .d_o(dv_d[i+1]), .rdy_i(dv_rdy[i+2 > NDV ? NDV : i+2])
    );
  end

  for (genvar i = 1; i < NDV; i++) begin : g_dv_rdy
    assign dv_rdy[i] = !dv_v[i] || dv_rdy[i+1];
  end

  // Decision stage: final ratio, status and rescale numerators.
  logic                   e1_v;
  dec_t                   e1_d;
  logic [mnr_pkg::RB-1:0] rf, dev;
  logic [mnr_pkg::RB-1:0] lim;
  logic [1:0]             st;
  logic                   sc;
  logic                   e2_rdy;

  assign e1_rdy = !e1_v || e2_rdy;

  always_comb begin
    mnr_pkg::rdiv_t x;
    x   = dv_d[NDV];
    rf  = !x.pos ? '0 : (x.sat ? '1 : x.r);
    dev = (rf > mnr_pkg::Q_ONE) ? rf - mnr_pkg::Q_ONE : mnr_pkg::Q_ONE - rf;
    lim = mnr_pkg::Q_ONE + mnr_pkg::RB'(tolerance);
    st  = mnr_pkg::ST_KEEP;
    sc  = 1'b0;
    if (x.pos) begin
      if (mode == mnr_pkg::MODE_RENORM) begin
        if (dev > mnr_pkg::RB'(tolerance)) begin
          st = mnr_pkg::ST_DRIFT;
        end else begin
          sc = 1'b1;
        end
      end else if (mode == mnr_pkg::MODE_CLAMP) begin
        if (rf > lim) begin
          st = mnr_pkg::ST_DRIFT;
        end else if (rf > mnr_pkg::Q_ONE) begin
          sc = 1'b1;
        end
      end
    end
    if (sc && rf != '0) begin
      st = mnr_pkg::ST_SCALE;
    end else begin
      sc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else if (e1_rdy) begin
      e1_v <= dv_v[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (e1_rdy && dv_v[NDV]) begin
      e1_d.vec    <= dv_d[NDV].vec;
      e1_d.r      <= rf;
      e1_d.status <= st;
      e1_d.scale  <= sc;
      e1_d.num[0] <= {mnr_pkg::mag(dv_d[NDV].vec.mx), 16'b0} + mnr_pkg::QW'(rf >> 1);
      e1_d.num[1] <= {mnr_pkg::mag(dv_d[NDV].vec.my), 16'b0} + mnr_pkg::QW'(rf >> 1);
      e1_d.num[2] <= {mnr_pkg::mag(dv_d[NDV].vec.mz), 16'b0} + mnr_pkg::QW'(rf >> 1);
    end
  end

  // Rescale setup: first remainder and overflow check per component.
  logic          rs_v   [NRS+1];
  mnr_pkg::rsc_t rs_d   [NRS+1];
  logic          rs_rdy [NRS+1];
  logic          f_rdy;

  assign e2_rdy       = !rs_v[0] || rs_rdy[1];
  assign rs_rdy[0]    = e2_rdy;
  assign rs_rdy[NRS]  = !rs_v[NRS] || f_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_v[0] <= 1'b0;
    end else if (e2_rdy) begin
      rs_v[0] <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (e2_rdy && e1_v) begin
      rs_d[0].vec    <= e1_d.vec;
      rs_d[0].r      <= e1_d.r;
      rs_d[0].status <= e1_d.status;
      rs_d[0].scale  <= e1_d.scale;
      for (int k = 0; k < 3; k++) begin
        rs_d[0].lanes[k].nl  <= e1_d.num[k][mnr_pkg::QB-1:0];
        rs_d[0].lanes[k].rem <= mnr_pkg::RW'(e1_d.num[k][mnr_pkg::QW-1:mnr_pkg::QB]);
        rs_d[0].lanes[k].q   <= '0;
        rs_d[0].lanes[k].ovf <= mnr_pkg::RW'(e1_d.num[k][mnr_pkg::QW-1:mnr_pkg::QB])
                                >= e1_d.r;
      end
    end
  end

  for (genvar i = 0; i < NRS; i++) begin : g_rs
    mnr_rsc_cell u_cell (
      .clk(clk), .rst(rst),
      .v_i(rs_v[i]), .d_i(rs_d[i]), .rdy_o(),
      .v_o(rs_v[i+1]), .d_o(rs_d[i+1]), .rdy_i(rs_rdy[i+2 > NRS ? NRS : i+2])
    );
  end

  for (genvar i = 1; i < NRS; i++) begin : g_rs_rdy
    assign rs_rdy[i] = !rs_v[i] || rs_rdy[i+1];
  end

  // Output register: sign, saturation and final selection.
  localparam logic [mnr_pkg::QB-1:0] POS_MAX = (mnr_pkg::QB'(1) << (mnr_pkg::DW-1)) - 1'b1;
  localparam logic [mnr_pkg::QB-1:0] NEG_MAX = mnr_pkg::QB'(1) << (mnr_pkg::DW-1);

  logic signed [mnr_pkg::DW-1:0] comp [3];
  logic signed [mnr_pkg::DW-1:0] scl  [3];

  always_comb begin
    mnr_pkg::rsc_t y;
    y       = rs_d[NRS];
    comp[0] = y.vec.mx;
    comp[1] = y.vec.my;
    comp[2] = y.vec.mz;
    for (int k = 0; k < 3; k++) begin
      if (comp[k][mnr_pkg::DW-1]) begin
        if (y.lanes[k].ovf || y.lanes[k].q > NEG_MAX) begin
          scl[k] = {1'b1, {(mnr_pkg::DW-1){1'b0}}};
        end else begin
          scl[k] = mnr_pkg::DW'(-y.lanes[k].q);
        end
      end else begin
        if (y.lanes[k].ovf || y.lanes[k].q > POS_MAX) begin
          scl[k] = {1'b0, {(mnr_pkg::DW-1){1'b1}}};
        end else begin
          scl[k] = mnr_pkg::DW'(y.lanes[k].q);
        end
      end
    end
  end

  assign f_rdy = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (f_rdy) begin
      result_valid <= rs_v[NRS];
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy && rs_v[NRS]) begin
      result.mx_out <= rs_d[NRS].scale ? scl[0] : comp[0];
      result.my_out <= rs_d[NRS].scale ? scl[1] : comp[1];
      result.mz_out <= rs_d[NRS].scale ? scl[2] : comp[2];
      result.ratio  <= rs_d[NRS].r;
      result.status <= rs_d[NRS].status;
    end
  end
endmodule

@@ src/mnr_check.sv @@
// Port-level checks for magnetization_renormalize_top, bound to it below.
// Depends on mnr_pkg.
module mnr_check (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input mnr_pkg::in_item_t   item,
  input logic                result_valid,
  input logic                result_stall,
  input mnr_pkg::out_item_t  result,
  input logic                cfg_wr,
  input logic                cfg_addr,
  input logic [15:0]         cfg_data
);
  // No result can leave right after reset; the pipe is empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == mnr_pkg::ST_KEEP ||
                      result.status == mnr_pkg::ST_SCALE ||
                      result.status == mnr_pkg::ST_DRIFT))
    else $error("bad status code");

  // A rescaled vector always carries a nonzero ratio.
  a_scale_ratio: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == mnr_pkg::ST_SCALE) |-> result.ratio != '0)
    else $error("rescale with zero ratio");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");
endmodule

bind magnetization_renormalize_top mnr_check u_mnr_check (.*);
